// ===== rtl/mi4_pkg.sv =====
// ----------------------------------------------------------------------------
// mi4_pkg: shared types and constants for the 4x4 matrix inverse
// Element format defaults and controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package mi4_pkg;

  localparam int unsigned ElemWidthDef = 32;
  localparam int unsigned FracBitsDef  = 16;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_LOADA = 4'd1,  // acc <= product of two stored values
    OP_MAC   = 4'd2,  // acc <= acc + product
    OP_MSUB  = 4'd3,  // acc <= acc - product
    OP_STM   = 4'd4,  // minor reg <= acc
    OP_STC   = 4'd5,  // cofactor[idx] <= +/- acc
    OP_DIV   = 4'd6   // start divider on cofactor[idx]
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] a_idx;   // element index for first operand
    logic [3:0] b_idx;   // element, minor or cofactor index for second operand
    logic       b_minor; // second operand is a stored 2x2 minor
    logic       b_cof;   // second operand is a stored cofactor
    logic       neg;     // negate when storing cofactor
    logic [3:0] c_idx;   // cofactor index
    logic [1:0] limb;    // limb of the second operand, lowest first
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic det_zero;
  } sts_t;

endpackage

// ===== rtl/matrix_inverse_4x4.sv =====
// ----------------------------------------------------------------------------
// matrix_inverse_4x4: 4x4 fixed-point inverse by adjugate
// Sixteen elements in, sixteen inverse elements out, row-major.
// ----------------------------------------------------------------------------
// Usage: stream sixteen signed Q elements on s_axis, row-major. On the
// sixteenth beat the block stops taking input and forms all sixteen
// cofactors on one shared multiplier that takes each product in four
// ELEM_WIDTH-bit limbs, one limb per cycle, then the determinant. Each
// result then runs a restoring divider, one quotient bit per cycle, and
// lands in an output register on m_axis. tuser carries the singular flag,
// tlast marks the sixteenth result. A zero determinant gives the identity
// with singular set. Input is taken again once the sixteenth result has
// been emitted. When m_axis stalls the result is held and the sequencer
// waits. Reset clears the load count and sequencer; stored elements are
// undefined until written.
// ----------------------------------------------------------------------------
module matrix_inverse_4x4 #(
  parameter int unsigned ELEM_WIDTH = mi4_pkg::ElemWidthDef,
  parameter int unsigned FRAC_BITS  = mi4_pkg::FracBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [ELEM_WIDTH-1:0] s_axis_tdata,   // [ELEM_WIDTH-1:0] element
  input  logic                  m_axis_tready,
  output logic                  m_axis_tvalid,
  output logic [ELEM_WIDTH-1:0] m_axis_tdata,   // [ELEM_WIDTH-1:0] inv_element
  output logic                  m_axis_tuser,   // [0] singular
  output logic                  m_axis_tlast
);
  import mi4_pkg::*;

  logic [3:0] load_q;
  logic       busy, start, emit;
  logic [3:0] emit_idx;
  cmd_t       cmd;
  sts_t       sts;
  logic [ELEM_WIDTH-1:0] result;
  logic       out_free;

  assign s_axis_tready = !busy && !start;
  wire in_beat = s_axis_tvalid && s_axis_tready;

  logic start_q;
  assign start = start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q  <= '0;
      start_q <= 1'b0;
    end else begin
      start_q <= in_beat && (load_q == 4'd15);
      if (in_beat) load_q <= load_q + 4'd1;
    end
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;

  mi4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .sts_i      (sts),
    .out_free_i (out_free),
    .cmd_o      (cmd),
    .emit_o     (emit),
    .emit_idx_o (emit_idx),
    .busy_o     (busy)
  );

  cmd_t dp_cmd;
  always_comb begin
    dp_cmd = cmd;
    if (emit) dp_cmd.c_idx = emit_idx;   // identity diagonal select
  end

  mi4_dp #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (in_beat),
    .wr_idx_i  (load_q),
    .wr_data_i (s_axis_tdata),
    .cmd_i     (dp_cmd),
    .sts_o     (sts),
    .result_o  (result)
  );

  logic vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (out_free) vld_q <= emit;
  end

  logic [ELEM_WIDTH-1:0] data_q;
  logic                  sing_q, last_q;
  always_ff @(posedge clk_i) begin
    if (emit) begin
      data_q <= result;
      sing_q <= sts.det_zero;
      last_q <= (emit_idx == 4'd15);
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = sing_q;
  assign m_axis_tlast  = last_q;

  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready) else $error("input taken while computing");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("stalled result changed");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> load_q == 4'd0) else $error("start without full matrix");

endmodule

// ===== rtl/mi4_ctrl.sv =====
// ----------------------------------------------------------------------------
// mi4_ctrl: sequencer for the adjugate inverse
// Walks the cofactor/determinant schedule and the per-result division steps.
// ----------------------------------------------------------------------------
module mi4_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  mi4_pkg::sts_t  sts_i,
  input  logic           out_free_i,
  output mi4_pkg::cmd_t  cmd_o,
  output logic           emit_o,
  output logic [3:0]     emit_idx_o,
  output logic           busy_o
);
  import mi4_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_COF  = 5'b00010,
    S_DET  = 5'b00100,
    S_DIV  = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] cof_q, cof_d;     // cofactor index (row*4+col)
  logic [4:0] step_q, step_d;   // step within a cofactor
  logic [3:0] res_q, res_d;     // result index
  logic [1:0] limb_q, limb_d;   // limb of the current product
  logic       is_mul;

  // rows/cols excluded
  logic [1:0] r, c;
  logic [1:0] rs [3];
  logic [1:0] cs [3];
  logic [1:0] ra, rb;       // rows of the 2x2 minor (rs[1], rs[2])

  always_comb begin
    r = cof_q[3:2];
    c = cof_q[1:0];
    rs[0] = (r == 2'd0) ? 2'd1 : 2'd0;
    rs[1] = (r <= 2'd1) ? 2'd2 : 2'd1;
    rs[2] = (r == 2'd3) ? 2'd2 : 2'd3;
    cs[0] = (c == 2'd0) ? 2'd1 : 2'd0;
    cs[1] = (c <= 2'd1) ? 2'd2 : 2'd1;
    cs[2] = (c == 2'd3) ? 2'd2 : 2'd3;
    ra = rs[1];
    rb = rs[2];
  end

  // Cofactor schedule, 13 steps:
  //  for term t in 0..2 (lead cs[t], minor cols x<y being the other two):
  //   step 3t+0: acc = m[ra][x]*m[rb][y]
  //   step 3t+1: acc -= m[ra][y]*m[rb][x]
  //   step 3t+2: minor[t] = acc
  //  steps 9,10,11: acc = +m[rs0][cs0]*minor0, -= m[rs0][cs1]*minor1, += ...
  //  step 12: store cofactor
  // Every product step is held for each of its four limbs in turn.
  logic [1:0] t, ph;
  logic [1:0] x, y;

  always_comb begin
    cmd_o        = '0;
    cmd_o.op     = OP_NONE;
    state_d      = state_q;
    cof_d        = cof_q;
    step_d       = step_q;
    res_d        = res_q;
    limb_d       = '0;
    emit_o       = 1'b0;
    if (step_q < 5'd3) begin
      t  = 2'd0;
      ph = step_q[1:0];
    end else if (step_q < 5'd6) begin
      t  = 2'd1;
      ph = 2'(step_q - 5'd3);
    end else begin
      t  = 2'd2;
      ph = 2'(step_q - 5'd6);
    end
    x            = cs[1];
    y            = cs[2];
    case (t)
      2'd0: begin x = cs[1]; y = cs[2]; end
      2'd1: begin x = cs[0]; y = cs[2]; end
      default: begin x = cs[0]; y = cs[1]; end
    endcase
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_COF;
          cof_d   = '0;
          step_d  = '0;
        end
      end
      S_COF: begin
        step_d = step_q + 5'd1;
        if (step_q < 5'd12) begin
          case (ph)
            2'd0: begin
              cmd_o.op    = OP_LOADA;
              cmd_o.a_idx = {ra, x};
              cmd_o.b_idx = {rb, y};
            end
            2'd1: begin
              cmd_o.op    = OP_MSUB;
              cmd_o.a_idx = {ra, y};
              cmd_o.b_idx = {rb, x};
            end
            2'd2: begin
              cmd_o.op    = OP_STM;
              cmd_o.b_idx = {2'd0, t};
            end
            default: begin
              cmd_o.op      = OP_NONE;
            end
          endcase
          if (step_q >= 5'd9) begin
            cmd_o.b_minor = 1'b1;
            cmd_o.a_idx   = {rs[0], cs[step_q[1:0] - 2'd1]};
            cmd_o.b_idx   = {2'd0, step_q[1:0] - 2'd1};
            case (step_q[1:0])
              2'd1:    cmd_o.op = OP_LOADA;
              2'd2:    cmd_o.op = OP_MSUB;
              default: cmd_o.op = OP_MAC;
            endcase
          end
        end else begin
          cmd_o.op    = OP_STC;
          cmd_o.c_idx = cof_q;
          cmd_o.neg   = r[0] ^ c[0];
          step_d      = '0;
          cof_d       = cof_q + 4'd1;
          if (cof_q == 4'd15) begin
            state_d = S_DET;
          end
        end
      end
      S_DET: begin
        step_d      = step_q + 5'd1;
        cmd_o.b_cof = 1'b1;
        cmd_o.a_idx = {2'd0, step_q[1:0]};
        cmd_o.b_idx = {2'd0, step_q[1:0]};
        cmd_o.op    = (step_q == 5'd0) ? OP_LOADA : OP_MAC;
        if (step_q == 5'd3) begin
          state_d = S_DIV;
          res_d   = '0;
          step_d  = '0;
        end
      end
      S_DIV: begin
        if (step_q == 5'd0) begin
          // adjugate: result (r,c) uses cofactor (c,r)
          cmd_o.op    = OP_DIV;
          cmd_o.c_idx = {res_q[1:0], res_q[3:2]};
          step_d      = 5'd1;
        end else if (step_q == 5'd1) begin
          step_d = 5'd2;  // divider picks up command
        end else if (!sts_i.div_busy) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free_i) begin
          emit_o = 1'b1;
          step_d = '0;
          res_d  = res_q + 4'd1;
          state_d = (res_q == 4'd15) ? S_IDLE : S_DIV;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // hold a product step until its last limb has gone through
    cmd_o.limb = limb_q;
    is_mul = (cmd_o.op == OP_LOADA) || (cmd_o.op == OP_MAC) || (cmd_o.op == OP_MSUB);
    if (is_mul && limb_q != 2'd3) begin
      limb_d  = limb_q + 2'd1;
      state_d = state_q;
      cof_d   = cof_q;
      step_d  = step_q;
      res_d   = res_q;
    end
  end

  assign emit_idx_o = res_q;
  assign busy_o     = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cof_q   <= '0;
      step_q  <= '0;
      res_q   <= '0;
      limb_q  <= '0;
    end else begin
      state_q <= state_d;
      cof_q   <= cof_d;
      step_q  <= step_d;
      res_q   <= res_d;
      limb_q  <= limb_d;
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> out_free_i) else $error("emit into full output");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DET && step_q == 5'd3 && limb_q == 2'd3)
    |=> (state_q == S_DIV && res_q == 4'd0))
    else $error("division phase entry");

endmodule

// ===== rtl/mi4_div.sv =====
// ----------------------------------------------------------------------------
// mi4_div: radix-2 restoring divider
// One quotient bit per cycle on unsigned magnitudes.
// ----------------------------------------------------------------------------
module mi4_div #(
  parameter int unsigned NW = 256,
  parameter int unsigned DW = 160
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o,
  output logic          busy_o
);
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] num_q, quo_q;
  logic [DW:0]   rem_q;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic [DW:0]   shifted;
  logic [DW+1:0] diff;

  always_comb begin
    shifted = {rem_q[DW-1:0], num_q[NW-1]};
    diff    = {1'b0, shifted} - {2'b00, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], 1'b0};
      if (!diff[DW+1]) begin
        rem_q <= diff[DW:0];
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
  end

  assign quo_o  = quo_q;
  assign busy_o = busy_q;

endmodule

// ===== rtl/mi4_dp.sv =====
// ----------------------------------------------------------------------------
// mi4_dp: matrix store, multiply-accumulate and division datapath
// Holds elements, minors and cofactors; forms the determinant and quotients.
// ----------------------------------------------------------------------------
module mi4_dp #(
  parameter int unsigned ELEM_WIDTH = mi4_pkg::ElemWidthDef,
  parameter int unsigned FRAC_BITS  = mi4_pkg::FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_i,
  input  logic [3:0]                   wr_idx_i,
  input  logic signed [ELEM_WIDTH-1:0] wr_data_i,
  input  mi4_pkg::cmd_t                cmd_i,
  output mi4_pkg::sts_t                sts_o,
  output logic [ELEM_WIDTH-1:0]        result_o
);
  import mi4_pkg::*;

  localparam int unsigned MW = 2 * ELEM_WIDTH + 1;   // 2x2 minor
  localparam int unsigned CW = 3 * ELEM_WIDTH + 3;   // cofactor
  localparam int unsigned AW = 4 * ELEM_WIDTH + 5;   // determinant
  localparam int unsigned BW = CW;                   // widest second operand
  localparam int unsigned NW = CW + 2 * FRAC_BITS;   // shifted numerator
  localparam int unsigned DW = AW;
  localparam int unsigned LW = ELEM_WIDTH;           // limb width
  localparam int unsigned XW = 4 * LW;               // second operand in limbs
  localparam int unsigned PW = 2 * LW + 1;           // limb product

  logic signed [ELEM_WIDTH-1:0] mem_q [16];
  logic signed [MW-1:0]         minor_q [3];
  logic signed [CW-1:0]         cof_q [16];
  logic signed [AW-1:0]         acc_q;
  logic signed [AW-1:0]         det_q;
  logic signed [ELEM_WIDTH-1:0] opa;
  logic signed [BW-1:0]         opb;
  logic signed [XW-1:0]         opb_x;
  logic signed [LW:0]           opb_limb;
  logic signed [PW-1:0]         part;
  logic signed [AW-1:0]         prod;
  logic                         nneg_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wr_idx_i] <= wr_data_i;
  end

  // one limb of the second operand per cycle; the top limb carries the sign
  always_comb begin
    opa = mem_q[cmd_i.a_idx];
    if (cmd_i.b_cof)        opb = BW'(cof_q[cmd_i.b_idx]);
    else if (cmd_i.b_minor) opb = BW'(minor_q[cmd_i.b_idx[1:0]]);
    else                    opb = BW'(mem_q[cmd_i.b_idx]);
    opb_x = XW'(opb);
    case (cmd_i.limb)
      2'd0:    opb_limb = {1'b0, opb_x[LW-1:0]};
      2'd1:    opb_limb = {1'b0, opb_x[2*LW-1:LW]};
      2'd2:    opb_limb = {1'b0, opb_x[3*LW-1:2*LW]};
      default: opb_limb = {opb_x[XW-1], opb_x[XW-1:3*LW]};
    endcase
    part = PW'(opa) * PW'(opb_limb);
    case (cmd_i.limb)
      2'd0:    prod = AW'(part);
      2'd1:    prod = AW'(part) << LW;
      2'd2:    prod = AW'(part) << (2 * LW);
      default: prod = AW'(part) << (3 * LW);
    endcase
  end

  logic signed [CW-1:0] cnum;
  logic [CW-1:0]        cmag;
  logic [DW-1:0]        dmag;
  logic                 dneg;

  always_comb begin
    cnum = cof_q[cmd_i.c_idx];
    cmag = cnum[CW-1] ? CW'(-cnum) : CW'(cnum);
    dneg = det_q[AW-1];
    dmag = dneg ? DW'(-det_q) : DW'(det_q);
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOADA: acc_q <= (cmd_i.limb == 2'd0) ? prod : acc_q + prod;
      OP_MAC:   acc_q <= acc_q + prod;
      OP_MSUB:  acc_q <= acc_q - prod;
      OP_STM:   minor_q[cmd_i.b_idx[1:0]] <= MW'(acc_q);
      OP_STC:   cof_q[cmd_i.c_idx] <= cmd_i.neg ? CW'(-acc_q) : CW'(acc_q);
      OP_DIV:   nneg_q <= cnum[CW-1];
      default:  ;
    endcase
    if (cmd_i.op == OP_MAC && cmd_i.b_cof && cmd_i.a_idx == 4'd3
        && cmd_i.limb == 2'd3) det_q <= acc_q + prod;
  end

  logic [NW-1:0] quo;
  logic          div_busy;

  mi4_div #(.NW(NW), .DW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == OP_DIV),
    .num_i   ({cmag, {(2*FRAC_BITS){1'b0}}}),
    .den_i   (dmag),
    .quo_o   (quo),
    .busy_o  (div_busy)
  );

  // sign fix and saturation
  localparam logic [NW-1:0] MaxPos = NW'({1'b0, {(ELEM_WIDTH-1){1'b1}}});
  logic                  qneg;
  logic [NW-1:0]         lim, qs;
  logic [ELEM_WIDTH-1:0] one_q;

  always_comb begin
    qneg  = (nneg_q != dneg) && (quo != '0);
    lim   = qneg ? MaxPos + NW'(1) : MaxPos;
    qs    = (quo > lim) ? lim : quo;
    one_q = (FRAC_BITS < ELEM_WIDTH - 1) ? ELEM_WIDTH'(1) << FRAC_BITS
                                         : {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    if (det_q == '0) begin
      result_o = '0;
      if (cmd_i.c_idx[3:2] == cmd_i.c_idx[1:0]) result_o = one_q;
    end else begin
      result_o = qneg ? ELEM_WIDTH'(-qs) : qs[ELEM_WIDTH-1:0];
    end
  end

  assign sts_o.div_busy = div_busy;
  assign sts_o.det_zero = (det_q == '0);

endmodule
